// ===== rtl/core/ivs_pkg.sv =====
// Shared types and codes for the indexed vector store.
package ivs_pkg;

	localparam int KW   = 3;
	localparam int PW   = 5;
	localparam int VW   = 32;
	localparam int CNTW = 5;

	localparam logic [KW-1:0] KIND_APPEND = 3'd0;
	localparam logic [KW-1:0] KIND_INSERT = 3'd1;
	localparam logic [KW-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KW-1:0] KIND_SET    = 3'd3;
	localparam logic [KW-1:0] KIND_GET    = 3'd4;
	localparam logic [KW-1:0] KIND_CLEAR  = 3'd5;

	typedef struct packed {
		logic [KW-1:0]        kind;
		logic [PW-1:0]        position;
		logic signed [VW-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VW-1:0] read_value;
		logic                 error;
		logic [CNTW-1:0]      element_count;
		logic                 is_empty;
	} rsp_t;

endpackage

// ===== rtl/core/indexed_vector_store.sv =====
// Top level of the indexed vector store: sequencer, element memory and result register.
//
// Ordered list of up to DEPTH signed 32-bit values with append, insert, remove,
// set, get and clear requests, one result word per request word. The list lives
// in a memory with one write and one registered read port; insert and remove
// move one element per cycle through that port pair, pipelined so a read at the
// source and the write of the previous element overlap. A request word is taken
// only while the sequencer is idle. Set, clear and refused requests go straight to
// the result step and a get waits for its read; insert and append move
// count - position elements (none for append) and remove count - position - 1,
// then the count steps and an insert writes its value. The result register
// parts the two sides: a new word is taken while the last result waits, and the
// sequencer holds in its final step only if that result is still stalled.
// Refused requests (full store, position out of range, unused kind) change
// nothing and report error with a zero read value. Element contents are not
// cleared at reset or by clear; only values read from positions below the count are ever used.
module indexed_vector_store #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ivs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ivs_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > ivs_pkg::PW) ? CW : ivs_pkg::PW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SHIFT  = 3'd1;
	localparam logic [2:0] ST_PLACE  = 3'd2;
	localparam logic [2:0] ST_GET    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	// element storage
	logic [ivs_pkg::VW-1:0] mem [DEPTH];
	logic [ivs_pkg::VW-1:0] rdata_q;

	// control state
	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          wpend_q;
	logic          rsp_valid_q;

	// operation context
	logic [XW-1:0]          moves_q;
	logic [AW-1:0]          src_q;
	logic [AW-1:0]          dst_q;
	logic [AW-1:0]          wdst_q;
	logic [AW-1:0]          pos_q;
	logic [ivs_pkg::VW-1:0] val_q;
	logic                   up_q;
	logic                   ins_q;
	logic                   res_err_q;
	logic [ivs_pkg::VW-1:0] res_val_q;
	ivs_pkg::rsp_t          rsp_q;

	// decode
	logic                   accept;
	logic                   out_free;
	logic [XW-1:0]          pos_x;
	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          ipos;
	logic [XW-1:0]          cnt_m1;
	logic [XW-1:0]          pos_p1;
	logic [XW-1:0]          mv_ins;
	logic [XW-1:0]          mv_rem;
	logic                   full;
	logic                   ins_ok;
	logic                   at_ok;
	logic                   req_err;
	logic                   mem_we;
	logic [AW-1:0]          mem_wa;
	logic [ivs_pkg::VW-1:0] mem_wd;
	logic [AW-1:0]          mem_ra;

	assign accept   = (state_q == ST_IDLE) && req_valid;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		pos_x  = XW'(req.position);
		cnt_x  = XW'(cnt_q);
		full   = (cnt_x == XW'(DEPTH));
		// append is an insert at the current end
		ipos   = (req.kind == ivs_pkg::KIND_APPEND) ? cnt_x : pos_x;
		ins_ok = !full && (ipos <= cnt_x);
		at_ok  = (pos_x < cnt_x);
		cnt_m1 = cnt_x - XW'(1);
		pos_p1 = pos_x + XW'(1);
		mv_ins = cnt_x - ipos;
		mv_rem = cnt_m1 - pos_x;
		case (req.kind)
			ivs_pkg::KIND_APPEND,
			ivs_pkg::KIND_INSERT: req_err = !ins_ok;
			ivs_pkg::KIND_REMOVE,
			ivs_pkg::KIND_SET,
			ivs_pkg::KIND_GET:    req_err = !at_ok;
			ivs_pkg::KIND_CLEAR:  req_err = 1'b0;
			default:              req_err = 1'b1;
		endcase
	end

	// One write port: a moved element, the placed insert value, or a set.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = wdst_q;
		mem_wd = rdata_q;
		if (wpend_q) begin
			mem_we = 1'b1;
		end else if ((state_q == ST_PLACE) && ins_q) begin
			mem_we = 1'b1;
			mem_wa = pos_q;
			mem_wd = val_q;
		end else if (accept && (req.kind == ivs_pkg::KIND_SET) && at_ok) begin
			mem_we = 1'b1;
			mem_wa = pos_x[AW-1:0];
			mem_wd = req.value;
		end
		// idle reads at the request position so a get has its data in the next cycle
		mem_ra = (state_q == ST_IDLE) ? pos_x[AW-1:0] : src_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_ra];
	end

	// sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			wpend_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a read issued in a shift step is written back in the next cycle
			wpend_q <= (state_q == ST_SHIFT) && (moves_q != '0);
			if ((state_q == ST_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_FINISH;
						case (req.kind)
							ivs_pkg::KIND_APPEND,
							ivs_pkg::KIND_INSERT: begin
								if (ins_ok) begin
									state_q <= ST_SHIFT;
								end
							end
							ivs_pkg::KIND_REMOVE: begin
								if (at_ok) begin
									state_q <= ST_SHIFT;
								end
							end
							ivs_pkg::KIND_GET: begin
								if (at_ok) begin
									state_q <= ST_GET;
								end
							end
							ivs_pkg::KIND_CLEAR: begin
								cnt_q <= '0;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					// the last write drains in this cycle, place next
					if (moves_q == '0) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: begin
					cnt_q   <= ins_q ? (cnt_q + CW'(1)) : (cnt_q - CW'(1));
					state_q <= ST_FINISH;
				end
				ST_GET: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operation context and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_err_q <= req_err;
				res_val_q <= '0;
				val_q     <= req.value;
				pos_q     <= ipos[AW-1:0];
				if (req.kind == ivs_pkg::KIND_REMOVE) begin
					// move down: element at pos+1 goes to pos, walking upward
					ins_q   <= 1'b0;
					up_q    <= 1'b0;
					moves_q <= mv_rem;
					dst_q   <= pos_x[AW-1:0];
					src_q   <= pos_p1[AW-1:0];
				end else begin
					// move up: element at count-1 goes to count, walking downward
					ins_q   <= 1'b1;
					up_q    <= 1'b1;
					moves_q <= mv_ins;
					dst_q   <= cnt_x[AW-1:0];
					src_q   <= cnt_m1[AW-1:0];
				end
			end
			ST_SHIFT: begin
				if (moves_q != '0) begin
					wdst_q  <= dst_q;
					moves_q <= moves_q - XW'(1);
					src_q   <= up_q ? (src_q - AW'(1)) : (src_q + AW'(1));
					dst_q   <= up_q ? (dst_q - AW'(1)) : (dst_q + AW'(1));
				end
			end
			ST_GET: begin
				res_val_q <= rdata_q;
			end
			ST_FINISH: begin
				if (out_free) begin
					rsp_q.read_value    <= res_val_q;
					rsp_q.error         <= res_err_q;
					rsp_q.element_count <= cnt_x[ivs_pkg::CNTW-1:0];
					rsp_q.is_empty      <= (cnt_q == '0);
				end
			end
			default: begin
				res_err_q <= res_err_q;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/ivs_checker.sv =====
// Port-level checker for the indexed vector store and its bind.
module ivs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ivs_pkg::rsp_t rsp
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

	// every taken request leaves the idle state, so an accept is followed by stall
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request word accepted twice in a row");

	// a refused request reports no data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error |-> rsp.read_value == '0)
		else $error("refused request carries read data");

	// empty flag agrees with the reported count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.element_count == '0)
		else $error("empty result with nonzero count");

endmodule

bind indexed_vector_store ivs_checker u_ivs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== test/list_result_checker.sv =====
// Result checker for the indexed vector store: shadow list, owed results and field compare.
`timescale 1ns / 100ps
module list_result_checker #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  ivs_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  ivs_pkg::rsp_t rsp,
	output int            mismatches,
	output int            pending,
	output int            checked,
	output int            refusals,
	output int            full_refusals
);

	localparam int VW   = ivs_pkg::VW;
	localparam int CNTW = ivs_pkg::CNTW;

	logic signed [VW-1:0] slot_vals [DEPTH];
	int                   fill = 0;
	ivs_pkg::rsp_t        owed_results [$];
	ivs_pkg::rsp_t        oldest;
	int                   bad = 0;
	int                   seen = 0;
	int                   refused = 0;
	int                   refused_full = 0;

	// Apply one request word to the shadow list; return the result word it owes.
	function automatic ivs_pkg::rsp_t list_apply(input ivs_pkg::req_t w);
		ivs_pkg::rsp_t r;
		int   at;
		int   i;
		logic ok;
		r = '0;
		ok = 1'b0;
		case (w.kind)
			ivs_pkg::KIND_APPEND, ivs_pkg::KIND_INSERT: begin
				at = (w.kind == ivs_pkg::KIND_APPEND) ? fill : int'(w.position);
				if (fill < DEPTH && at <= fill) begin
					for (i = fill; i > at; i--)
						slot_vals[i] = slot_vals[i-1];
					slot_vals[at] = w.value;
					fill++;
					ok = 1'b1;
				end else if (fill >= DEPTH) begin
					refused_full++;
				end
			end
			ivs_pkg::KIND_REMOVE: begin
				if (int'(w.position) < fill) begin
					for (i = int'(w.position); i + 1 < fill; i++)
						slot_vals[i] = slot_vals[i+1];
					fill--;
					ok = 1'b1;
				end
			end
			ivs_pkg::KIND_SET: begin
				ok = int'(w.position) < fill;
				if (ok)
					slot_vals[w.position] = w.value;
			end
			ivs_pkg::KIND_GET: begin
				ok = int'(w.position) < fill;
				if (ok)
					r.read_value = slot_vals[w.position];
			end
			ivs_pkg::KIND_CLEAR: begin
				fill = 0;
				ok = 1'b1;
			end
			default: ok = 1'b0;
		endcase
		if (!ok)
			refused++;
		r.error = !ok;
		r.element_count = CNTW'(fill);
		r.is_empty = (fill == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [VW-1:0] want,
			input logic [VW-1:0] got);
		if (want !== got) begin
			bad++;
			if (bad <= 10)
				$display("checker: result %0d, %s expected 0x%08h got 0x%08h",
					seen, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			owed_results.delete();
		end else begin
			// results first: a word leaving at this edge belongs to an earlier request
			if (rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("checker: result word with no request outstanding (count %0d)",
							rsp.element_count);
				end else begin
					oldest = owed_results.pop_front();
					check_field("read_value", oldest.read_value, rsp.read_value);
					check_field("error", oldest.error, rsp.error);
					check_field("element_count", oldest.element_count, rsp.element_count);
					check_field("is_empty", oldest.is_empty, rsp.is_empty);
					seen++;
				end
			end
			if (req_valid && !req_stall)
				owed_results.push_back(list_apply(req));
		end
		mismatches    <= bad;
		pending       <= owed_results.size();
		checked       <= seen;
		refusals      <= refused;
		full_refusals <= refused_full;
	end

endmodule

// ===== test/tb.sv =====
// Top of the indexed vector store testbench: clock, reset, request words, stalls and verdict.
`timescale 1ns / 100ps
module tb;

	localparam int KW           = ivs_pkg::KW;
	localparam int PW           = ivs_pkg::PW;
	localparam int VW           = ivs_pkg::VW;
	localparam int DEPTH        = 16;
	localparam int RAND_WORDS   = 900;
	localparam int PHASE_WORDS  = 45;
	localparam int CALM_WORDS   = 150;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 400000;

	// Kind codes the block leaves undefined; both must come back refused.
	localparam logic [KW-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KW-1:0] KIND_SPARE_HI = 3'd7;

	// Traffic mixes for the random part: fill up, drain down, or churn around the middle.
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

	logic          clk;
	logic          arst_n    = 1'b1;
	logic          req_valid = 1'b0;
	logic          req_stall;
	ivs_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	ivs_pkg::rsp_t rsp;

	int   mismatches;
	int   pending;
	int   checked;
	int   refusals;
	int   full_refusals;

	int   sent       = 0;
	int   last_count = 0;
	int   gap_pct    = 0;
	int   stall_pct  = 0;
	int   stall_hold = 0;
	logic calm       = 1'b0;

	logic [VW-1:0] extreme_vals [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

	indexed_vector_store #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	list_result_checker #(
		.DEPTH(DEPTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked),
		.refusals     (refusals),
		.full_refusals(full_refusals)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (longest shifts, gaps and stalls on every word).
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	// Result-side back pressure: random stall bursts between open windows.
	// Drop the stall at once and hold it off entirely once the run goes calm.
	always @(posedge clk) begin
		if (calm) begin
			rsp_stall  <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if ($urandom_range(0, 99) >= stall_pct) begin
			rsp_stall  <= 1'b0;
			stall_hold <= $urandom_range(0, 6);
		end else begin
			rsp_stall  <= 1'b1;
			stall_hold <= $urandom_range(0, 12);
		end
	end

	// Track the count reported by the block; it only steers positions toward the live range.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			last_count <= rsp.element_count;
	end

	function automatic ivs_pkg::req_t make_word(input logic [KW-1:0] kind,
			input logic [PW-1:0] position, input logic [VW-1:0] value);
		ivs_pkg::req_t w;
		w.kind     = kind;
		w.position = position;
		w.value    = value;
		return w;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 45;
		endcase
	endfunction

	// Draw one request word; the mix sets how hard the list is pushed toward full or empty.
	function automatic ivs_pkg::req_t random_word(input mix_t mix);
		ivs_pkg::req_t w;
		int   r;
		int   add_w;
		int   rem_w;
		case (mix)
			MIX_GROW: begin
				add_w = 55;
				rem_w = 10;
			end
			MIX_SHRINK: begin
				add_w = 15;
				rem_w = 50;
			end
			default: begin
				add_w = 30;
				rem_w = 30;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < add_w)
			w.kind = $urandom_range(0, 1) ? ivs_pkg::KIND_APPEND : ivs_pkg::KIND_INSERT;
		else if (r < add_w + rem_w)
			w.kind = ivs_pkg::KIND_REMOVE;
		else if (r < 88)
			w.kind = $urandom_range(0, 1) ? ivs_pkg::KIND_SET : ivs_pkg::KIND_GET;
		else if (r < 90)
			w.kind = ivs_pkg::KIND_CLEAR;
		else
			w.kind = KW'($urandom_range(ivs_pkg::KIND_APPEND, KIND_SPARE_HI));
		// mostly inside or just past the live range, sometimes anywhere in the field
		if ($urandom_range(0, 99) < 80)
			w.position = PW'($urandom_range(0, last_count));
		else
			w.position = PW'($urandom);
		if ($urandom_range(0, 99) < 12)
			w.value = extreme_vals[$urandom_range(0, 3)];
		else
			w.value = $urandom;
		return w;
	endfunction

	// Offer one word, after an optional idle burst; return once it is taken.
	task automatic send_word(input ivs_pkg::req_t w);
		if ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	initial begin : stimulus
		int   i;
		int   phase_left;
		mix_t mix;
		mix = MIX_GROW;
		phase_left = 0;

		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 15;
		stall_pct <= 25;

		// Empty store: reads and removes are refused.
		send_word(make_word(ivs_pkg::KIND_GET, 5'd0, 32'h0));
		send_word(make_word(ivs_pkg::KIND_REMOVE, 5'd0, 32'h0));
		// Fill to the brim, extreme values first.
		for (i = 0; i < DEPTH; i++)
			send_word(make_word(ivs_pkg::KIND_APPEND, PW'(i),
				(i < 4) ? extreme_vals[i] : VW'($urandom)));
		// Full store: append and insert are refused and change nothing.
		send_word(make_word(ivs_pkg::KIND_APPEND, 5'd0, 32'h0000_0001));
		send_word(make_word(ivs_pkg::KIND_INSERT, 5'd0, 32'h0000_0002));
		send_word(make_word(ivs_pkg::KIND_GET, 5'd15, 32'h0));
		send_word(make_word(ivs_pkg::KIND_GET, 5'd16, 32'h0));
		// Longest shifts: remove the head, then insert a new head ahead of the old elements.
		send_word(make_word(ivs_pkg::KIND_REMOVE, 5'd0, 32'h0));
		send_word(make_word(ivs_pkg::KIND_INSERT, 5'd0, 32'h5A5A_5A5A));
		// Remove the tail, then insert at the end, which acts as an append.
		send_word(make_word(ivs_pkg::KIND_REMOVE, 5'd15, 32'h0));
		send_word(make_word(ivs_pkg::KIND_INSERT, 5'd15, 32'hA5A5_A5A5));
		send_word(make_word(ivs_pkg::KIND_SET, 5'd31, 32'hFFFF_FFFF));
		send_word(make_word(ivs_pkg::KIND_SET, 5'd7, 32'h8000_0000));
		send_word(make_word(ivs_pkg::KIND_GET, 5'd7, 32'h0));
		// Undefined kinds with every other bit set.
		send_word(make_word(KIND_SPARE_LO, 5'd31, 32'hFFFF_FFFF));
		send_word(make_word(KIND_SPARE_HI, 5'd31, 32'hFFFF_FFFF));
		// Clear, then insert past the end of the now empty list.
		send_word(make_word(ivs_pkg::KIND_CLEAR, 5'd31, 32'hFFFF_FFFF));
		send_word(make_word(ivs_pkg::KIND_INSERT, 5'd1, 32'h1234_5678));

		// Random part: phases of one traffic mix each, with their own idling;
		// the last stretch runs with no idling on either side.
		for (i = 0; i < RAND_WORDS; i++) begin
			if (i == RAND_WORDS - CALM_WORDS) begin
				gap_pct = 0;
				calm <= 1'b1;
				mix = MIX_CHURN;
				phase_left = RAND_WORDS;
			end else if (phase_left == 0) begin
				phase_left = PHASE_WORDS;
				mix = mix_t'($urandom_range(0, 2));
				gap_pct = pick_pct();
				stall_pct <= pick_pct();
			end
			phase_left--;
			send_word(random_word(mix));
		end
		req_valid <= 1'b0;

		// Drain: wait for every owed result, then give the block time for a stray one.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d request words sent, %0d results checked, %0d refused by the store",
			sent, checked, refusals);
		$display("tb: %0d append or insert words turned away by a full store", full_refusals);
		if (mismatches == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
